### sv/i2cra_pkg.sv
package i2cra_pkg;

    // default for the longest read reply, in bytes
    localparam int unsigned READ_BYTES_DEF = 4;
    // bytes held in the fetched word
    localparam int unsigned WORD_BYTES     = 4;
    localparam int unsigned WORD_IDX_W     = $clog2(WORD_BYTES);

    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        EV_ADDR_MATCH = 2'd0,
        EV_BYTE_READY = 2'd1,
        EV_STOP       = 2'd2,
        EV_NO_FLAG    = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        RESP_NONE = 2'd0,
        RESP_ACK  = 2'd1,
        RESP_NACK = 2'd2
    } t_response;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_REP_WRITE   = 2'd1,
        ERR_READ_NO_REP = 2'd2,
        ERR_NO_FLAG     = 2'd3
    } t_error;

    typedef struct packed {
        t_event      op;
        logic        dir_read;
        logic        rep_start;
        logic [7:0]  rx_byte;
        logic        fetch_ok;
        logic [31:0] fetch_word;
        logic [2:0]  fetch_len;
    } t_in_item;

    typedef struct packed {
        t_response   response;
        logic        release_line;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        cmd_valid;
        logic        cmd_is_read;
        logic [7:0]  cmd_reg;
        logic [7:0]  cmd_data;
        t_error      error_code;
        logic        ready_res;
    } t_out_item;

endpackage

### sv/i2cra_core.sv
module i2cra_core #(
    parameter int unsigned READ_BYTES = i2cra_pkg::READ_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  i2cra_pkg::t_in_item  i_item,
    output i2cra_pkg::t_out_item o_res
);
    import i2cra_pkg::*;

    localparam int unsigned LEN_W = $clog2(READ_BYTES + 1);

    logic             r_is_read_dir, n_is_read_dir;
    logic             r_saw_rep_start, n_saw_rep_start;
    logic [7:0]       r_reg_address, n_reg_address;
    logic [7:0]       r_data_byte, n_data_byte;
    logic [31:0]      r_read_word, n_read_word;
    logic [LEN_W-1:0] r_read_len, n_read_len;
    logic [7:0]       r_byte_count, n_byte_count;

    logic [7:0]       cnt_inc;
    logic [7:0]       tx_sel;

    assign cnt_inc = r_byte_count + 8'd1;

    // byte at old count, zero beyond the fetched word
    always_comb begin
        if (r_byte_count < 8'(WORD_BYTES)) begin
            tx_sel = r_read_word[8 * int'(r_byte_count[WORD_IDX_W-1:0]) +: 8];
        end else begin
            tx_sel = 8'd0;
        end
    end

    always_comb begin
        n_is_read_dir   = r_is_read_dir;
        n_saw_rep_start = r_saw_rep_start;
        n_reg_address   = r_reg_address;
        n_data_byte     = r_data_byte;
        n_read_word     = r_read_word;
        n_read_len      = r_read_len;
        n_byte_count    = r_byte_count;
        o_res           = '0;

        unique case (i_item.op)
            EV_ADDR_MATCH: begin
                n_is_read_dir   = i_item.dir_read;
                n_saw_rep_start = i_item.rep_start;
                n_byte_count    = 8'd0;
                o_res.ready_res = 1'b1;
                if (i_item.rep_start == i_item.dir_read) begin
                    o_res.response = RESP_ACK;
                end else begin
                    o_res.response   = RESP_NACK;
                    o_res.error_code = i_item.dir_read ? ERR_READ_NO_REP : ERR_REP_WRITE;
                end
            end
            EV_BYTE_READY: begin
                n_byte_count = cnt_inc;
                if (!r_is_read_dir) begin
                    o_res.response = RESP_ACK;
                    if (cnt_inc == 8'd1) begin
                        // first byte of a write is the register address
                        n_reg_address   = i_item.rx_byte;
                        n_data_byte     = 8'd0;
                        o_res.ready_res = 1'b1;
                    end else begin
                        n_data_byte       = i_item.rx_byte;
                        o_res.cmd_valid   = 1'b1;
                        o_res.cmd_reg     = r_reg_address;
                        o_res.cmd_data    = i_item.rx_byte;
                    end
                end else if (cnt_inc == 8'd1) begin
                    if (!i_item.fetch_ok) begin
                        o_res.response     = RESP_NACK;
                        o_res.release_line = 1'b1;
                        o_res.ready_res    = 1'b1;
                    end else begin
                        n_read_word = i_item.fetch_word;
                        if (32'(i_item.fetch_len) > READ_BYTES) begin
                            n_read_len = LEN_W'(READ_BYTES);
                        end else begin
                            n_read_len = LEN_W'(i_item.fetch_len);
                        end
                        o_res.cmd_valid   = 1'b1;
                        o_res.cmd_is_read = 1'b1;
                        o_res.cmd_reg     = r_reg_address;
                        o_res.cmd_data    = r_data_byte;
                        o_res.tx_valid    = 1'b1;
                        o_res.tx_byte     = i_item.fetch_word[7:0];
                    end
                end else if (cnt_inc > 8'd1 && cnt_inc <= 8'(r_read_len)) begin
                    o_res.tx_valid  = 1'b1;
                    o_res.tx_byte   = tx_sel;
                    o_res.ready_res = 1'b1;
                end else if ({1'b0, cnt_inc} == 9'(r_read_len) + 9'd1) begin
                    // master asked past the end of the reply
                    o_res.response     = RESP_NACK;
                    o_res.release_line = 1'b1;
                    o_res.ready_res    = 1'b1;
                end
            end
            EV_STOP: begin
                n_byte_count    = 8'd0;
                o_res.ready_res = 1'b1;
            end
            EV_NO_FLAG: begin
                o_res.error_code = ERR_NO_FLAG;
                o_res.ready_res  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_read_dir   <= 1'b0;
            r_saw_rep_start <= 1'b0;
            r_reg_address   <= 8'd0;
            r_data_byte     <= 8'd0;
            r_read_word     <= 32'd0;
            r_read_len      <= '0;
            r_byte_count    <= 8'd0;
        end else if (i_fire) begin
            r_is_read_dir   <= n_is_read_dir;
            r_saw_rep_start <= n_saw_rep_start;
            r_reg_address   <= n_reg_address;
            r_data_byte     <= n_data_byte;
            r_read_word     <= n_read_word;
            r_read_len      <= n_read_len;
            r_byte_count    <= n_byte_count;
        end
    end

endmodule

### sv/i2c_register_access_slave_unit.sv
// register-access i2c slave event handler: each input item is one decoded
// bus event (address match, byte ready, stop or no flag) and yields exactly
// one result item with the ack/nack action, line release, transmit byte,
// register command, error code and ready-line level. an item is taken into
// an input register, decided by one level of logic against the transfer
// state and written to a result register; a new one can enter every
// cycle, and only a stalled result register holds the input side back.
// read replies are limited to READ_BYTES bytes of the fetched 32-bit
// word, least significant byte first
module i2c_register_access_slave_unit #(
    parameter int unsigned READ_BYTES = i2cra_pkg::READ_BYTES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // dir_read[0], rep_start[1], rx_byte[9:2], fetch_ok[10],
    // fetch_word[42:11], fetch_len[45:43], zero fill[47:46]
    input  logic [i2cra_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // op[1:0]
    input  logic [i2cra_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // response[1:0], release_line[2], tx_valid[3], tx_byte[11:4],
    // cmd_valid[12], cmd_is_read[13], cmd_reg[21:14], cmd_data[29:22],
    // error_code[31:30], ready_res[32], zero fill[39:33]
    output logic [i2cra_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import i2cra_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item core_res;
    logic      advance;

    // item moves from input register to result register when the
    // result register is empty or its item is being taken
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // unpack the incoming item
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.op         <= t_event'(s_axis_tuser[1:0]);
            r_in_item.dir_read   <= s_axis_tdata[0];
            r_in_item.rep_start  <= s_axis_tdata[1];
            r_in_item.rx_byte    <= s_axis_tdata[9:2];
            r_in_item.fetch_ok   <= s_axis_tdata[10];
            r_in_item.fetch_word <= s_axis_tdata[42:11];
            r_in_item.fetch_len  <= s_axis_tdata[45:43];
        end
    end

    // event decision and transfer state
    i2cra_core #(
        .READ_BYTES (READ_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (r_in_item),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    // pack the result item, lowest field first
    assign m_axis_tdata = {
        7'd0,
        r_out_item.ready_res,
        r_out_item.error_code,
        r_out_item.cmd_data,
        r_out_item.cmd_reg,
        r_out_item.cmd_is_read,
        r_out_item.cmd_valid,
        r_out_item.tx_byte,
        r_out_item.tx_valid,
        r_out_item.release_line,
        r_out_item.response
    };

endmodule
